// ===== rtl/lcdmt_pkg.sv =====
package lcdmt_pkg;

   // Scanline timing, in dots
   localparam logic [9:0] OAM_END     = 10'd80;
   localparam logic [9:0] XFER_END    = 10'd252;
   localparam logic [9:0] LINE_DOTS   = 10'd456;
   localparam logic [7:0] VBLANK_LINE = 8'd144;
   localparam logic [7:0] FRAME_LINES = 8'd154;

   // Mode codes
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // One time-advance request
   typedef struct packed {
      logic [5:0] elapsed;
      logic       lcd_on;
      logic       hblank_irq_en;
      logic       vblank_irq_en;
      logic       oam_irq_en;
      logic       match_irq_en;
      logic [7:0] compare_line;
   } req_type;

   // One result
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
      logic       hblank_pulse;
      logic       draw_pulse;
      logic       frame_pulse;
   } rsp_type;

endpackage

// ===== rtl/lcd_mode_timing_controller_top.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | req_data (lcdmt_pkg::req_type)
// rsp     | out       | rsp_valid / rsp_ready  | rsp_data (lcdmt_pkg::rsp_type)
//
// One request per clock while the result is not stalled; its result appears in the
// result register on the next cycle, when the dot, mode and line registers update.
// A request is taken whenever the result register is empty or being emptied.
// Synchronous active-high reset: line 0, OAM search, dot counter 0, flags clear.
// A stalled result holds the block; nothing is dropped.
module lcd_mode_timing_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lcdmt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lcdmt_pkg::rsp_type rsp_data
);

   logic [9:0] dot_ff, dot_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] line_ff, line_in;
   logic       prev_stat_ff, prev_stat_in;
   logic       match_ff, match_in;
   logic       rsp_valid_ff;
   lcdmt_pkg::rsp_type rsp_ff, rsp_in;

   logic [9:0] dot_sum;
   logic [7:0] line_inc;
   logic       stat_level;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dot_sum  = dot_ff + {4'd0, req_data.elapsed};
   assign line_inc = line_ff + 8'd1;

   // Next state and result for one time advance
   always_comb begin
      dot_in       = dot_ff;
      mode_in      = mode_ff;
      line_in      = line_ff;
      match_in     = match_ff;
      stat_level   = 1'b0;
      rsp_in       = '0;
      if (!req_data.lcd_on) begin
         mode_in = lcdmt_pkg::MODE_VBLANK;
         line_in = 8'd0;
      end else begin
         dot_in = dot_sum;
         unique case (mode_ff)
            lcdmt_pkg::MODE_OAM: begin
               if (dot_sum >= lcdmt_pkg::OAM_END) mode_in = lcdmt_pkg::MODE_XFER;
            end
            lcdmt_pkg::MODE_XFER: begin
               if (dot_sum >= lcdmt_pkg::XFER_END) begin
                  mode_in             = lcdmt_pkg::MODE_HBLANK;
                  rsp_in.hblank_pulse = 1'b1;
                  stat_level          = req_data.hblank_irq_en;
               end
            end
            lcdmt_pkg::MODE_HBLANK: begin
               if (dot_sum >= lcdmt_pkg::LINE_DOTS) begin
                  dot_in            = dot_sum - lcdmt_pkg::LINE_DOTS;
                  rsp_in.draw_pulse = 1'b1;
                  line_in           = line_inc;
                  if (line_inc == lcdmt_pkg::VBLANK_LINE) begin
                     mode_in           = lcdmt_pkg::MODE_VBLANK;
                     rsp_in.vblank_irq = 1'b1;
                     stat_level        = req_data.vblank_irq_en;
                  end else begin
                     mode_in    = lcdmt_pkg::MODE_OAM;
                     stat_level = req_data.oam_irq_en;
                  end
               end
            end
            lcdmt_pkg::MODE_VBLANK: begin
               if (dot_sum >= lcdmt_pkg::LINE_DOTS) begin
                  dot_in  = dot_sum - lcdmt_pkg::LINE_DOTS;
                  line_in = line_inc;
                  if (line_inc == lcdmt_pkg::FRAME_LINES) begin
                     rsp_in.frame_pulse = 1'b1;
                     mode_in            = lcdmt_pkg::MODE_OAM;
                     line_in            = 8'd0;
                     stat_level         = req_data.oam_irq_en;
                  end
               end
            end
            default: ;
         endcase
         // line compare
         match_in = (line_in == req_data.compare_line);
         if (match_in && req_data.match_irq_en) stat_level = 1'b1;
         rsp_in.stat_irq = stat_level && !prev_stat_ff;
      end
      prev_stat_in       = stat_level;
      rsp_in.mode        = mode_in;
      rsp_in.line        = line_in;
      rsp_in.coincidence = match_in;
   end

   // Timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff       <= 10'd0;
         mode_ff      <= lcdmt_pkg::MODE_OAM;
         line_ff      <= 8'd0;
         prev_stat_ff <= 1'b0;
         match_ff     <= 1'b0;
      end else if (accept) begin
         dot_ff       <= dot_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         prev_stat_ff <= prev_stat_in;
         match_ff     <= match_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   // Checks
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.lcd_on |=>
         rsp_ff.mode == lcdmt_pkg::MODE_VBLANK && rsp_ff.line == 8'd0 && !rsp_ff.stat_irq)
      else $error("disabled request did not force vblank, line 0");

   a_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_pulse |->
         rsp_ff.line == 8'd0 && rsp_ff.mode == lcdmt_pkg::MODE_OAM)
      else $error("frame pulse without wrap to OAM search at line 0");

   a_vblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.vblank_irq |->
         rsp_ff.line == lcdmt_pkg::VBLANK_LINE && rsp_ff.draw_pulse)
      else $error("vblank request away from line 144");

   a_stat_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stat_irq |-> prev_stat_ff)
      else $error("STAT request without the stored level set");

   a_state_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.mode == mode_ff && rsp_ff.line == line_ff)
      else $error("result disagrees with timing state");

endmodule
